FILE: rtl/kbw_pkg.sv
// Package for the Kaiser-Bessel window coefficient generator.
// Holds the fixed-point formats and constants; depends on nothing.
package kbw_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int SIZE_W     = 13;
   localparam int INDEX_W    = 12;
   localparam int COEF_W     = 16;
   localparam int TERM_W     = FRAC_BITS + 1;
   localparam int Q_W        = 33;
   localparam int DS_W       = 33;
   localparam int SUM_W      = 34;
   localparam int RECIP_SHIFT = 33;
   localparam int RECIP_W    = 34;

   localparam logic [TERM_W-1:0] ONE_Q28 = TERM_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0] ALPHA_SQ_QUARTER_Q28 = 33'd4963371581;
   localparam logic [DS_W-1:0] NORM_Q28 = 33'd357694;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

endpackage

FILE: rtl/kaiser_bessel_window_coefficient_top.sv
// Kaiser-Bessel window coefficient generator, alpha 8.6, fully pipelined.
// Stages: index preparation, 29 restoring divider stages, three squaring
// stages, four stages per series term and one rounding stage. Throughput
// is one transaction per cycle; busy stays low. Synchronous reset clears
// the valid pipeline and sets window_size to 4096.
module kaiser_bessel_window_coefficient_top
   import kbw_pkg::*;
#(
   parameter int MAX_SIZE     = 4096,
   parameter int SERIES_TERMS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [INDEX_W-1:0]  req_sample_index,
   output logic                rsp_valid,
   output logic [COEF_W-1:0]   rsp_coefficient,
   output logic                rsp_index_out_of_range,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_window_size
);

   localparam int DIV_STAGES = TERM_W;

   logic [SIZE_W-1:0] size_ff;
   logic [16:0]       size_limit;
   logic [SIZE_W-1:0] size_use;
   logic [SIZE_W-1:0] mid;
   logic [SIZE_W-1:0] mirror;
   logic              in_oor;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign size_limit = 17'(MAX_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_window_size;
      end
   end

   always_comb begin
      size_use = ({4'b0, size_ff} > size_limit) ? size_limit[SIZE_W-1:0] : size_ff;
      in_oor   = {1'b0, req_sample_index} >= size_use;
      mid      = SIZE_W'(({1'b0, size_use} + 14'd1) >> 1);
      mirror   = {1'b0, req_sample_index};
      if (mirror >= mid) begin
         mirror = size_use - 13'd1 - {1'b0, req_sample_index};
      end
   end

   // Divider pipeline: index 0 holds the prepared operands.
   logic                vld_ff  [0:DIV_STAGES];
   logic                oor_ff  [0:DIV_STAGES];
   logic [SIZE_W-1:0]   rem_ff  [0:DIV_STAGES];
   logic [SIZE_W-1:0]   mid_ff  [0:DIV_STAGES];
   logic [TERM_W-1:0]   quo_ff  [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
      end
      oor_ff[0] <= in_oor;
      rem_ff[0] <= mid - mirror;
      mid_ff[0] <= mid;
      quo_ff[0] <= '0;
   end

   genvar i;
   generate
      for (i = 0; i < DIV_STAGES; i++) begin : g_div
         logic [SIZE_W:0]   cand;
         logic              ge;
         logic [SIZE_W:0]   diff;
         always_comb begin
            if (i == 0) begin
               cand = {1'b0, rem_ff[i]};
            end else begin
               cand = {rem_ff[i], 1'b0};
            end
            ge   = cand >= {1'b0, mid_ff[i]};
            diff = cand - {1'b0, mid_ff[i]};
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i+1] <= 1'b0;
            end else begin
               vld_ff[i+1] <= vld_ff[i];
            end
            oor_ff[i+1] <= oor_ff[i];
            mid_ff[i+1] <= mid_ff[i];
            rem_ff[i+1] <= ge ? diff[SIZE_W-1:0] : cand[SIZE_W-1:0];
            quo_ff[i+1] <= {quo_ff[i][TERM_W-2:0], ge};
         end
      end
   endgenerate

   // Squaring and argument stages.
   logic                   sq_vld_ff, t_vld_ff, q_vld_ff;
   logic                   sq_oor_ff, t_oor_ff, q_oor_ff;
   logic [2*TERM_W-1:0]    sq_prod_ff;
   logic [TERM_W-1:0]      t_ff;
   logic [Q_W+TERM_W-1:0]  q_prod_ff;
   logic [TERM_W:0]        sq_val;

   assign sq_val = sq_prod_ff[2*TERM_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         t_vld_ff  <= 1'b0;
         q_vld_ff  <= 1'b0;
      end else begin
         sq_vld_ff <= vld_ff[DIV_STAGES];
         t_vld_ff  <= sq_vld_ff;
         q_vld_ff  <= t_vld_ff;
      end
      sq_oor_ff  <= oor_ff[DIV_STAGES];
      t_oor_ff   <= sq_oor_ff;
      q_oor_ff   <= t_oor_ff;
      sq_prod_ff <= quo_ff[DIV_STAGES] * quo_ff[DIV_STAGES];
      t_ff       <= (sq_val >= {1'b0, ONE_Q28}) ? '0 : TERM_W'({1'b0, ONE_Q28} - sq_val);
      q_prod_ff  <= ALPHA_SQ_QUARTER_Q28 * t_ff;
   end

   // Power series: four stages per term.
   logic              sv_ff  [0:SERIES_TERMS];
   logic              so_ff  [0:SERIES_TERMS];
   logic [Q_W-1:0]    sq_ff  [0:SERIES_TERMS];
   logic [DS_W-1:0]   sd_ff  [0:SERIES_TERMS];
   logic [SUM_W-1:0]  ss_ff  [0:SERIES_TERMS];

   always_comb begin
      sv_ff[0] = q_vld_ff;
      so_ff[0] = q_oor_ff;
      sq_ff[0] = q_prod_ff[Q_W+FRAC_BITS-1:FRAC_BITS];
      sd_ff[0] = NORM_Q28;
      ss_ff[0] = SUM_W'(NORM_Q28);
   end

   genvar k;
   generate
      for (k = 1; k <= SERIES_TERMS; k++) begin : g_term
         localparam longint unsigned DIVISOR = k * k;
         localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
         localparam logic [10:0] DIV_C = 11'(DIVISOR);

         logic [3:0]           v_ff;
         logic [3:0]           o_ff;
         logic [Q_W-1:0]       q_a_ff, q_b_ff, q_c_ff;
         logic [SUM_W-1:0]     s_a_ff, s_b_ff, s_c_ff;
         logic [2*Q_W-1:0]     prod_a;
         logic [DS_W-1:0]      x_a_ff, x_b_ff, x_c_ff;
         logic [DS_W+RECIP_W-1:0] px_ff;
         logic [DS_W-1:0]      qa_ff;
         logic [DS_W+10:0]     back;
         logic [DS_W:0]        rem;
         logic [DS_W-1:0]      ds;

         assign prod_a = sd_ff[k-1] * sq_ff[k-1];
         assign back   = qa_ff * DIV_C;
         assign rem    = {1'b0, x_c_ff} - (DS_W+1)'(back);
         assign ds     = qa_ff + DS_W'(rem >= {{(DS_W-10){1'b0}}, DIV_C});

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff <= '0;
            end else begin
               v_ff <= {v_ff[2:0], sv_ff[k-1]};
            end
            o_ff   <= {o_ff[2:0], so_ff[k-1]};
            q_a_ff <= sq_ff[k-1];
            s_a_ff <= ss_ff[k-1];
            x_a_ff <= prod_a[DS_W+FRAC_BITS-1:FRAC_BITS];
            q_b_ff <= q_a_ff;
            s_b_ff <= s_a_ff;
            x_b_ff <= x_a_ff;
            px_ff  <= x_a_ff * RECIP;
            q_c_ff <= q_b_ff;
            s_c_ff <= s_b_ff;
            x_c_ff <= x_b_ff;
            qa_ff  <= px_ff[RECIP_SHIFT+DS_W-1:RECIP_SHIFT];
            sq_ff[k] <= q_c_ff;
            sd_ff[k] <= ds;
            ss_ff[k] <= s_c_ff + SUM_W'(ds);
         end
         assign sv_ff[k] = v_ff[3];
         assign so_ff[k] = o_ff[3];
      end
   endgenerate

   // Rounding, saturation and the out-of-range override.
   logic [SUM_W:0] rnd;

   assign rnd = {1'b0, ss_ff[SERIES_TERMS]} + (SUM_W+1)'(2048);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= sv_ff[SERIES_TERMS];
      end
      rsp_index_out_of_range <= so_ff[SERIES_TERMS];
      if (so_ff[SERIES_TERMS]) begin
         rsp_coefficient <= '0;
      end else if (|rnd[SUM_W:28]) begin
         rsp_coefficient <= '1;
      end else begin
         rsp_coefficient <= rnd[27:12];
      end
   end

endmodule

FILE: dv/kbw_checker.sv
// Checker for the Kaiser-Bessel window coefficient generator: watches the
// request, result and register channels, predicts each coefficient and compares.
// Depends on kbw_pkg for widths and fixed-point constants.
`timescale 1ns / 1ps
module kbw_checker
   import kbw_pkg::*;
#(
   parameter int MAX_SIZE     = 4096,
   parameter int SERIES_TERMS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [INDEX_W-1:0] req_sample_index,
   input  logic               rsp_valid,
   input  logic [COEF_W-1:0]  rsp_coefficient,
   input  logic               rsp_index_out_of_range,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_window_size,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count
);

   typedef struct packed {
      logic [COEF_W-1:0] coefficient;
      logic              out_of_range;
   } window_point_type;

   logic [SIZE_W-1:0] size_shadow;
   window_point_type  expected_points[$];

   function automatic window_point_type window_coefficient(logic [INDEX_W-1:0] idx,
                                                          logic [SIZE_W-1:0] size_reg);
      window_point_type r;
      logic [63:0] size, mid, j, term, sq, t, q, ds, sum, coef;
      size = 64'(size_reg);
      if (size > 64'(MAX_SIZE)) size = 64'(MAX_SIZE);
      r.coefficient  = '0;
      r.out_of_range = 1'b1;
      if (64'(idx) >= size) return r;
      mid = (size + 64'd1) / 64'd2;
      j = 64'(idx);
      if (j >= mid) j = size - 64'd1 - j;
      term = ((mid - j) << FRAC_BITS) / mid;
      sq = (term * term) >> FRAC_BITS;
      t = (sq >= (64'd1 << FRAC_BITS)) ? 64'd0 : (64'd1 << FRAC_BITS) - sq;
      q = (64'(ALPHA_SQ_QUARTER_Q28) * t) >> FRAC_BITS;
      ds = 64'(NORM_Q28);
      sum = ds;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         ds = (ds * q) >> FRAC_BITS;
         ds = ds / 64'(k * k);
         sum += ds;
      end
      coef = (sum + 64'd2048) >> 12;
      if (coef > 64'd65535) coef = 64'd65535;
      r.coefficient  = coef[COEF_W-1:0];
      r.out_of_range = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_points.size();

   always @(posedge clock) begin
      window_point_type want;
      if (reset) begin
         size_shadow <= SIZE_RESET;
         expected_points.delete();
         fail_count   = 0;
         result_count = 0;
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_coefficient, -1);
            end else begin
               want = expected_points.pop_front();
               if (rsp_coefficient !== want.coefficient)
                  report_mismatch("coefficient", rsp_coefficient, want.coefficient);
               if (rsp_index_out_of_range !== want.out_of_range)
                  report_mismatch("index_out_of_range", rsp_index_out_of_range,
                                  want.out_of_range);
            end
         end
         if (start && !busy)
            expected_points.push_back(window_coefficient(req_sample_index, size_shadow));
         if (csr_valid && csr_ready) size_shadow <= csr_window_size;
      end
   end

endmodule

FILE: dv/tb_kaiser_bessel_window_coefficient_top.sv
// Testbench top for the Kaiser-Bessel window coefficient generator: drives
// window sizes and sample indices and gives the verdict. Depends on kbw_pkg,
// the block and kbw_checker.
`timescale 1ns / 1ps
module tb_kaiser_bessel_window_coefficient_top;
   import kbw_pkg::*;

   localparam int LATENCY     = 34 + 4 * 24;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [INDEX_W-1:0] req_sample_index = '0;
   logic               rsp_valid;
   logic [COEF_W-1:0]  rsp_coefficient;
   logic               rsp_index_out_of_range;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SIZE_W-1:0]  csr_window_size = '0;
   int                 fail_count, pending_count, result_count;
   int                 cycle_count = 0;
   int                 sent_count = 0;
   logic [SIZE_W-1:0]  active_size;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kaiser_bessel_window_coefficient_top dut (.*);

   kbw_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("kaiser_bessel_window_coefficient_top regression: fail");
         $finish;
      end
   end

   task automatic send_index(logic [INDEX_W-1:0] idx, bit calm);
      while (!calm && $urandom_range(99) < 14) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_sample_index = idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      start = 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] size);
      drain_pipeline();
      csr_valid = 1'b1;
      csr_window_size = size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      active_size = size;
   endtask

   function automatic logic [INDEX_W-1:0] pick_index(logic [SIZE_W-1:0] size);
      int s;
      s = (size > 4096) ? 4096 : int'(size);
      if (s == 0 || $urandom_range(9) == 0) return INDEX_W'($urandom);
      return INDEX_W'($urandom_range(s - 1));
   endfunction

   initial begin
      logic [SIZE_W-1:0] sizes[$];
      active_size = SIZE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed: extremes, middle of the window, mirror point, out of range.
      send_index(12'd0, 1);
      send_index(12'd2047, 1);
      send_index(12'd2048, 1);
      send_index(12'd4095, 1);
      write_size(13'd1);
      send_index(12'd0, 1);
      send_index(12'd1, 1);
      write_size(13'd0);
      send_index(12'd0, 1);
      send_index(12'd4095, 1);
      write_size(13'd8191);
      send_index(12'd0, 1);
      send_index(12'd4095, 1);
      send_index(12'd2048, 1);
      write_size(13'd2);
      send_index(12'd0, 1);
      send_index(12'd1, 1);
      send_index(12'd2, 1);
      write_size(13'd5);
      for (int i = 0; i < 6; i++) send_index(INDEX_W'(i), 1);
      // Random phases over a spread of sizes, one calm stretch in the sixth phase.
      sizes = {13'd4096, 13'd1, 13'd7, 13'd64, 13'd4097, 13'd1000, 13'd3, 13'd8191,
               13'd2, 13'd0, 13'd2731};
      for (int p = 0; p < 16; p++) begin
         if (p < sizes.size()) write_size(sizes[p]);
         else write_size(SIZE_W'($urandom_range(8191)));
         for (int n = 0; n < 100; n++) send_index(pick_index(active_size), p == 5);
      end
      drain_pipeline();
      $display("Sent %0d index transactions across 21 window size writes and checked %0d results.",
               sent_count, result_count);
      if (fail_count == 0) begin
         $display("kaiser_bessel_window_coefficient_top regression: pass");
      end else begin
         $display("kaiser_bessel_window_coefficient_top regression: fail");
      end
      $finish;
   end

endmodule
